>>> hw/rtl/simt_vector_alu_branch_mask_core_macros.svh
// Assertion helpers used by the queue RTL. Each use expects clk and rst_n in scope.
`ifndef SIMT_VECTOR_ALU_BRANCH_MASK_CORE_MACROS_SVH
`define SIMT_VECTOR_ALU_BRANCH_MASK_CORE_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define SVABM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define SVABM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/svabm_pkg.sv
`timescale 1ns / 1ps

package svabm_pkg;

    localparam int NUM_LANES   = 32;
    localparam int LANE_W      = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int MASK_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_AND   = 4'd1,
        OP_SLL   = 4'd2,
        OP_SUB   = 4'd3,
        OP_VID   = 4'd4,
        OP_BCAST = 4'd5,
        OP_SEQ   = 4'd6,
        OP_SNE   = 4'd7,
        OP_SGE   = 4'd8,
        OP_SLT   = 4'd9,
        OP_SGEU  = 4'd10,
        OP_SLTU  = 4'd11
    } op_t;

    typedef enum logic {
        KIND_ALU    = 1'b0,
        KIND_BRANCH = 1'b1
    } kind_t;

    // One classified lane, as it travels from front to back.
    typedef struct packed {
        op_t               op;
        logic              rev;
        logic              en;
        logic [31:0]       a;
        logic [31:0]       b;
        logic [31:0]       tgt;
        logic [2:0]        warp;
        logic              last;
        logic [LANE_W-1:0] lane;
        logic              is_branch;
        logic              holds;
    } item_t;

endpackage

>>> hw/rtl/svabm_front.sv
`timescale 1ns / 1ps

module svabm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         operation,
    input  logic               reverse_operands,
    input  logic               lane_enable,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic [31:0]        branch_target,
    input  logic [2:0]         warp_number,
    input  logic               final_lane,
    input  logic               queue_full,
    output logic               push,
    output svabm_pkg::item_t   item
);
    import svabm_pkg::*;

    logic [LANE_W-1:0] lane_reg;
    logic [LANE_W-1:0] lane_next;
    op_t               op;
    logic              is_branch;
    logic              holds;

    assign op       = op_t'(operation);
    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        unique case (op)
            OP_SEQ, OP_SNE, OP_SGE, OP_SLT, OP_SGEU, OP_SLTU: is_branch = 1'b1;
            default:                                          is_branch = 1'b0;
        endcase
    end

    // Compare reads as "b versus a".
    always_comb
    begin
        unique case (op)
            OP_SEQ:  holds = (operand_a == operand_b);
            OP_SNE:  holds = (operand_a != operand_b);
            OP_SGE:  holds = (operand_b >= operand_a);
            OP_SLT:  holds = (operand_b < operand_a);
            OP_SGEU: holds = ($unsigned(operand_b) >= $unsigned(operand_a));
            default: holds = ($unsigned(operand_b) < $unsigned(operand_a));
        endcase
    end

    always_comb
    begin
        if (final_lane || (lane_reg == LANE_W'(NUM_LANES - 1)))
            lane_next = '0;
        else
            lane_next = lane_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else if (push)
            lane_reg <= lane_next;
    end

    always_comb
    begin
        item.op        = op;
        item.rev       = reverse_operands;
        item.en        = lane_enable;
        item.a         = operand_a;
        item.b         = operand_b;
        item.tgt       = branch_target;
        item.warp      = warp_number;
        item.last      = final_lane;
        item.lane      = lane_reg;
        item.is_branch = is_branch;
        item.holds     = holds;
    end

endmodule

>>> hw/rtl/svabm_queue.sv
`timescale 1ns / 1ps

`include "simt_vector_alu_branch_mask_core_macros.svh"

module svabm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  svabm_pkg::item_t push_item,
    output logic             full,
    output logic             not_empty,
    input  logic             pop,
    output svabm_pkg::item_t head
);
    import svabm_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        priority if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    `SVABM_ASSERT_SAME(a_no_push_full, full, !push, "push into a full queue")
    `SVABM_ASSERT_SAME(a_no_pop_empty, !not_empty, !pop, "pop from an empty queue")
    `SVABM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")

endmodule

>>> hw/rtl/svabm_back.sv
`timescale 1ns / 1ps

module svabm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  svabm_pkg::item_t   head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [31:0] lane_value,
    output logic [4:0]         lane_number,
    output logic [2:0]         warp_out,
    output logic [31:0]        taken_else_mask,
    output logic [31:0]        taken_if_mask,
    output logic [31:0]        else_target,
    output logic               run_end
);
    import svabm_pkg::*;

    // Per-instruction state, rewritten on every lane 0.
    logic [31:0]       bcast_reg;
    logic [MASK_W-1:0] else_reg;
    logic [MASK_W-1:0] if_reg;
    logic [31:0]       target_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    kind_t             kind_reg;
    logic [31:0]       value_reg;
    logic [4:0]        lane_out_reg;
    logic [2:0]        warp_reg;
    logic [MASK_W-1:0] else_out_reg;
    logic [MASK_W-1:0] if_out_reg;
    logic [31:0]       target_out_reg;
    logic              end_reg;

    logic              first;
    logic [31:0]       bcast_eff;
    logic [31:0]       target_eff;
    logic [MASK_W-1:0] lane_bit;
    logic [MASK_W-1:0] else_next;
    logic [MASK_W-1:0] if_next;
    logic [31:0]       alu_value;
    logic [31:0]       lane_wide;
    logic              produces;

    assign first      = (head.lane == '0);
    assign bcast_eff  = first ? head.a : bcast_reg;
    assign target_eff = first ? head.tgt : target_reg;
    assign lane_wide  = 32'(head.lane);
    assign produces   = !head.is_branch || head.last;
    assign pop        = head_valid && (!out_valid_reg || out_ready);

    // Lanes beyond the mask width match no bit.
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
            lane_bit[i] = head.en && (int'(head.lane) == i);
    end

    always_comb
    begin
        else_next = first ? '0 : else_reg;
        if_next   = first ? '0 : if_reg;
        if (head.is_branch)
        begin
            if (head.holds)
                else_next = else_next | lane_bit;
            else
                if_next = if_next | lane_bit;
        end
    end

    always_comb
    begin
        unique case (head.op)
            OP_ADD:   alu_value = head.en ? head.a + head.b : '0;
            OP_AND:   alu_value = head.en ? head.a & head.b : '0;
            OP_SLL:
            begin
                if (!head.en)
                    alu_value = '0;
                else if (head.rev)
                    alu_value = head.b << head.a[4:0];
                else
                    alu_value = head.a << head.b[4:0];
            end
            OP_SUB:
            begin
                if (!head.en)
                    alu_value = '0;
                else if (head.rev)
                    alu_value = head.b - head.a;
                else
                    alu_value = head.a - head.b;
            end
            OP_VID:   alu_value = lane_wide;
            OP_BCAST: alu_value = bcast_eff;
            default:  alu_value = '0;
        endcase
    end

    always_comb
    begin
        priority if (pop && produces)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bcast_reg  <= bcast_eff;
            target_reg <= target_eff;
            else_reg   <= else_next;
            if_reg     <= if_next;
        end
        if (pop && produces)
        begin
            lane_out_reg <= lane_wide[4:0];
            warp_reg     <= head.warp;
            end_reg      <= head.last;
            if (head.is_branch)
            begin
                kind_reg       <= KIND_BRANCH;
                value_reg      <= '0;
                else_out_reg   <= else_next;
                if_out_reg     <= if_next;
                target_out_reg <= target_eff;
            end
            else
            begin
                kind_reg       <= KIND_ALU;
                value_reg      <= alu_value;
                else_out_reg   <= '0;
                if_out_reg     <= '0;
                target_out_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign lane_value      = value_reg;
    assign lane_number     = lane_out_reg;
    assign warp_out        = warp_reg;
    assign taken_else_mask = else_out_reg;
    assign taken_if_mask   = if_out_reg;
    assign else_target     = target_out_reg;
    assign run_end         = end_reg;

endmodule

>>> hw/rtl/simt_vector_alu_branch_mask_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Carries
// in        sink       in_valid / in_ready   one lane of a warp instruction
// out       source     out_valid / out_ready one lane result or one branch mask
//
// One lane per cycle sustained while out_ready holds. A lane is written into the
// queue at the edge it transfers; its result is then loaded from the queue head
// into the output register and transfers out from there.
// Front: lane counter plus decode and compare. Back: ALU, mask gather, output
// register. A two-entry queue sits between them.
// Reset clears the lane counter, queue pointers and output valid; the first
// lane after reset is lane 0, which reloads all per-instruction state.
// A stall on out holds the output register; the queue absorbs up to two lanes
// before in_ready drops.

module simt_vector_alu_branch_mask_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         operation,
    input  logic               reverse_operands,
    input  logic               lane_enable,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic [31:0]        branch_target,
    input  logic [2:0]         warp_number,
    input  logic               final_lane,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [31:0] lane_value,
    output logic [4:0]         lane_number,
    output logic [2:0]         warp_out,
    output logic [31:0]        taken_else_mask,
    output logic [31:0]        taken_if_mask,
    output logic [31:0]        else_target,
    output logic               run_end
);
    import svabm_pkg::*;

    // Front to queue.
    logic  push;
    item_t push_item;
    logic  queue_full;

    // Queue to back.
    logic  head_valid;
    item_t head;
    logic  pop;

    // Count lanes and classify each one as it transfers in.
    svabm_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .reverse_operands (reverse_operands),
        .lane_enable      (lane_enable),
        .operand_a        (operand_a),
        .operand_b        (operand_b),
        .branch_target    (branch_target),
        .warp_number      (warp_number),
        .final_lane       (final_lane),
        .queue_full       (queue_full),
        .push             (push),
        .item             (push_item)
    );

    // Hold classified lanes so either side can stall alone.
    svabm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .not_empty (head_valid),
        .pop       (pop),
        .head      (head)
    );

    // Execute lanes in order; branch lanes only emit on the final lane.
    svabm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .lane_value      (lane_value),
        .lane_number     (lane_number),
        .warp_out        (warp_out),
        .taken_else_mask (taken_else_mask),
        .taken_if_mask   (taken_if_mask),
        .else_target     (else_target),
        .run_end         (run_end)
    );

endmodule
